// ----- design/amsr_pkg.sv -----
// Package for the MFM sector reader: widths, event kinds, status codes and helpers.
// No dependencies.
package amsr_pkg;

	localparam int MaxSectorsDefault = 16;
	localparam int WordsPerSector = 128;
	localparam logic [31:0] MfmMask = 32'h5555_5555;

	typedef enum logic [1:0] {
		KIND_SYNC  = 2'd0,
		KIND_WORD  = 2'd1,
		KIND_RESYNC = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IGNORED   = 4'd0,
		ST_PROGRESS  = 4'd1,
		ST_DATA      = 4'd2,
		ST_HDR_OK    = 4'd3,
		ST_HDR_SUM   = 4'd4,
		ST_CYL_WRONG = 4'd5,
		ST_HEAD_WRONG = 4'd6,
		ST_SEC_OK    = 4'd7,
		ST_DATA_SUM  = 4'd8,
		ST_RESYNC    = 4'd9,
		ST_SEC_RANGE = 4'd10
	} status_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] half;
	} item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] data_word;
		logic [7:0]  sector_number;
		logic        head_number;
		logic [6:0]  word_index;
		logic [5:0]  sectors_detected;
		logic [5:0]  sectors_good;
	} result_t;

	function automatic logic [31:0] swap_bytes(input logic [31:0] v);
		swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

// ----- design/amsr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module amsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/amsr_fifo.sv -----
// Two-entry queue of items or results, used between the parts of the sector reader.
// No package dependencies.
module amsr_fifo #(
	parameter int WIDTH = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] data_q [2];
	logic             wptr_q, rptr_q;
	logic [1:0]       count_q;
	logic             do_push, do_pop;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = data_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ----- design/amsr_back.sv -----
// Back part of the sector reader: sector state machine, odd-half store and tallies.
// Depends on amsr_pkg and amsr_ram.
module amsr_back
	import amsr_pkg::*;
#(
	parameter int MAX_SECTORS = MaxSectorsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] expected_cylinder,
	input  logic       expected_head,
	input  logic       in_valid,
	input  item_t      in_item,
	output logic       in_take,
	output logic       out_valid,
	output result_t    out_result,
	input  logic       out_ready
);

	localparam int MapBits = 2 * MAX_SECTORS;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0, PH_HDR1 = 3'd1, PH_HDR2 = 3'd2, PH_LABEL = 3'd3,
		PH_HSUM = 3'd4, PH_DSUM = 3'd5, PH_DATA = 3'd6
	} phase_t;

	phase_t            phase_q;
	logic [7:0]        word_count_q;
	logic [31:0]       sum_q;
	logic [31:0]       header_q;
	logic [MapBits-1:0] det_map_q, good_map_q;
	logic [5:0]        det_cnt_q, good_cnt_q;
	logic [6:0]        rd_addr_q;

	// Second stage: data word completion after the RAM read.
	logic              valid_s2;
	result_t           res_s2;
	logic              join_s2;
	logic [31:0]       half_s2;
	logic [31:0]       odd_rdata;

	logic              advance;
	logic              ram_we;
	logic [6:0]        ram_raddr;
	logic [31:0]       new_sum;
	logic [7:0]        sec;
	logic              hd;
	logic [6:0]        cyl;
	logic [5:0]        map_idx;
	logic [MapBits-1:0] bit_oh;

	assign advance = !valid_s2 || out_ready;
	assign in_take = in_valid && advance;
	assign out_valid = valid_s2;

	always_comb begin
		out_result = res_s2;
		if (join_s2) begin
			out_result.data_word = swap_bytes(odd_rdata | half_s2);
		end
	end

	assign new_sum = sum_q ^ in_item.half;
	assign sec = header_q[15:8];
	assign hd = header_q[16];
	assign cyl = header_q[23:17];
	assign map_idx = 6'(sec) + (hd ? 6'(MAX_SECTORS) : 6'd0);
	assign bit_oh = MapBits'(1) << map_idx;
	assign ram_we = in_take && in_item.kind == KIND_WORD && phase_q == PH_DATA
		&& !word_count_q[7];
	// While the second stage is held, the store keeps reading the held word's address.
	assign ram_raddr = advance ? word_count_q[6:0] : rd_addr_q;

	amsr_ram #(.WIDTH(32), .DEPTH(WordsPerSector)) u_odd_store (
		.clk(clk),
		.we(ram_we),
		.waddr(word_count_q[6:0]),
		.wdata({in_item.half[30:0], 1'b0}),
		.raddr(ram_raddr),
		.rdata(odd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			word_count_q <= '0;
			sum_q <= '0;
			header_q <= '0;
			det_map_q <= '0;
			good_map_q <= '0;
			det_cnt_q <= '0;
			good_cnt_q <= '0;
			rd_addr_q <= '0;
			valid_s2 <= 1'b0;
			res_s2 <= '0;
			join_s2 <= 1'b0;
			half_s2 <= '0;
		end else if (advance) begin
			valid_s2 <= in_take;
			join_s2 <= 1'b0;
			half_s2 <= in_item.half;
			rd_addr_q <= word_count_q[6:0];
			if (in_take) begin
				logic [3:0] st;
				logic [6:0] widx;
				logic [31:0] hdr_n;
				logic [5:0] dc, gc;
				st = ST_PROGRESS;
				widx = '0;
				hdr_n = header_q;
				dc = det_cnt_q;
				gc = good_cnt_q;
				unique case (kind_t'(in_item.kind))
					KIND_SYNC: begin
						phase_q <= PH_HDR1;
						sum_q <= '0;
						word_count_q <= '0;
					end
					KIND_RESYNC: begin
						phase_q <= PH_IDLE;
						st = ST_RESYNC;
					end
					KIND_CLEAR: begin
						det_map_q <= '0;
						good_map_q <= '0;
						dc = '0;
						gc = '0;
					end
					default: begin
						unique case (phase_q)
							PH_HDR1: begin
								hdr_n = {in_item.half[30:0], 1'b0};
								sum_q <= new_sum;
								phase_q <= PH_HDR2;
							end
							PH_HDR2: begin
								hdr_n = header_q | in_item.half;
								sum_q <= new_sum;
								word_count_q <= '0;
								phase_q <= PH_LABEL;
							end
							PH_LABEL: begin
								sum_q <= new_sum;
								if (word_count_q == 8'd7) begin
									word_count_q <= '0;
									phase_q <= PH_HSUM;
								end else begin
									word_count_q <= word_count_q + 8'd1;
								end
							end
							PH_HSUM: begin
								sum_q <= new_sum;
								if (word_count_q == 8'd1) begin
									word_count_q <= '0;
									phase_q <= PH_IDLE;
									if (new_sum != '0) begin
										st = ST_HDR_SUM;
									end else if (cyl != expected_cylinder) begin
										st = ST_CYL_WRONG;
									end else if (hd != expected_head) begin
										st = ST_HEAD_WRONG;
									end else if (sec >= 8'(MAX_SECTORS)) begin
										st = ST_SEC_RANGE;
									end else begin
										if ((det_map_q & bit_oh) == '0) begin
											det_map_q <= det_map_q | bit_oh;
											if (dc != 6'd63) begin
												dc = dc + 6'd1;
											end
										end
										st = ST_HDR_OK;
										sum_q <= '0;
										phase_q <= PH_DSUM;
									end
								end else begin
									word_count_q <= word_count_q + 8'd1;
								end
							end
							PH_DSUM: begin
								sum_q <= new_sum;
								if (word_count_q == 8'd1) begin
									word_count_q <= '0;
									phase_q <= PH_DATA;
								end else begin
									word_count_q <= word_count_q + 8'd1;
								end
							end
							PH_DATA: begin
								sum_q <= new_sum;
								word_count_q <= word_count_q + 8'd1;
								if (word_count_q[7]) begin
									join_s2 <= 1'b1;
									widx = word_count_q[6:0];
									st = ST_DATA;
									if (word_count_q == 8'd255) begin
										phase_q <= PH_IDLE;
										if (new_sum == '0) begin
											if ((good_map_q & bit_oh) == '0) begin
												good_map_q <= good_map_q | bit_oh;
												if (gc != 6'd63) begin
													gc = gc + 6'd1;
												end
											end
											st = ST_SEC_OK;
										end else begin
											st = ST_DATA_SUM;
										end
									end
								end
							end
							default: begin
								phase_q <= PH_IDLE;
								st = ST_IGNORED;
							end
						endcase
					end
				endcase
				header_q <= hdr_n;
				det_cnt_q <= dc;
				good_cnt_q <= gc;
				res_s2.status <= st;
				res_s2.data_word <= '0;
				res_s2.sector_number <= hdr_n[15:8];
				res_s2.head_number <= hdr_n[16];
				res_s2.word_index <= widx;
				res_s2.sectors_detected <= dc;
				res_s2.sectors_good <= gc;
			end
		end
	end

endmodule

// ----- design/amiga_mfm_sector_reader_top.sv -----
// Top level of the MFM sector reader: input queue, sector back end and result queue.
// Depends on amsr_pkg, amsr_fifo and amsr_back.
//
// Events enter through a queue interface: an event is taken when push is high and full
// is low. kind selects sync mark, raw MFM word, error resync or clearing of the track
// tallies; raw_word carries the 32 raw cells of a word. The front part masks out the
// clock bits and queues the event in a two-entry queue.
// Every event gives exactly one result, offered while empty is low and taken when pop
// is high. The result carries a status, the decoded byte-swapped data longword, the
// sector and head of the current header, the word index and the two sector counts.
// A result passes the input queue, the result register and the output queue; one event
// per cycle is sustained while results are popped, set by the single pass through the
// sector state machine and the registered read of the 128-entry odd-half store.
// When the receiver stalls, results gather in the output queue, then the back end
// holds, then the input queue fills and full rises; nothing is lost.
// Reset clears all state, tallies and queues (not the odd-half store); configuration
// writes set the expected cylinder and head and take effect on the next event.
module amiga_mfm_sector_reader_top
	import amsr_pkg::*;
#(
	parameter int MAX_SECTORS = MaxSectorsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [31:0] raw_word,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  status,
	output logic [31:0] data_word,
	output logic [7:0]  sector_number,
	output logic        head_number,
	output logic [6:0]  word_index,
	output logic [5:0]  sectors_detected,
	output logic [5:0]  sectors_good,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	logic [6:0] exp_cyl_q;
	logic       exp_head_q;
	item_t      front_item, queued_item;
	logic       q_empty, q_take;
	logic       back_valid, res_full;
	result_t    back_res, out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cyl_q <= '0;
			exp_head_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				exp_cyl_q <= cfg_data;
			end else begin
				exp_head_q <= cfg_data[0];
			end
		end
	end

	assign front_item.kind = kind;
	assign front_item.half = raw_word & MfmMask;

	amsr_fifo #(.WIDTH($bits(item_t))) u_in_q (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(front_item), .full(full),
		.pop(q_take), .rdata(queued_item), .empty(q_empty)
	);

	amsr_back #(.MAX_SECTORS(MAX_SECTORS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.expected_cylinder(exp_cyl_q), .expected_head(exp_head_q),
		.in_valid(!q_empty), .in_item(queued_item), .in_take(q_take),
		.out_valid(back_valid), .out_result(back_res), .out_ready(!res_full)
	);

	amsr_fifo #(.WIDTH($bits(result_t))) u_out_q (
		.clk(clk), .arst_n(arst_n),
		.push(back_valid), .wdata(back_res), .full(res_full),
		.pop(pop), .rdata(out_res), .empty(empty)
	);

	assign status = out_res.status;
	assign data_word = out_res.data_word;
	assign sector_number = out_res.sector_number;
	assign head_number = out_res.head_number;
	assign word_index = out_res.word_index;
	assign sectors_detected = out_res.sectors_detected;
	assign sectors_good = out_res.sectors_good;

endmodule
